@@ hw/rtl/uer_pkg.sv @@
// Package for the ultrasonic echo ranger: phase encoding, register indexes,
// and the fixed field widths and scale constants.
// No dependencies.
package uer_pkg;

    localparam int CntW   = 16;
    localparam int DistW  = 21;
    localparam int BoundW = 20;
    localparam int AddrW  = 3;
    localparam int DataW  = 32;

    localparam logic [4:0]        MCM_PER_TICK = 5'd17;
    localparam logic [BoundW-1:0] MCM_PER_CM   = 20'd1000;

    typedef enum logic [4:0] {
        PH_IDLE      = 5'b00001,
        PH_TRIG_LOW  = 5'b00010,
        PH_TRIG_HIGH = 5'b00100,
        PH_WAIT_ECHO = 5'b01000,
        PH_MEASURE   = 5'b10000
    } phase_t;

    typedef enum logic [AddrW-1:0] {
        REG_MIN_DIST     = 3'd0,
        REG_MAX_DIST     = 3'd1,
        REG_WINDOW       = 3'd2,
        REG_ECHO_TIMEOUT = 3'd3,
        REG_TRIG_HIGH    = 3'd4,
        REG_TRIG_LOW     = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic             trigger_level;
        logic             measure_done;
        logic [DistW-1:0] distance_mcm;
        logic             in_range;
        logic             timed_out;
        logic             window_done;
        logic             config_error;
    } result_t;

endpackage

@@ hw/rtl/ultrasonic_echo_ranger_unit.sv @@
// Ultrasonic echo ranger top level: trigger sequencing, echo timing, range check.
// Depends on uer_pkg.
//
// channel   direction  handshake              payload
// in        input      in_valid / in_ready    start_req, echo_level
// out       output     out_valid / out_ready  trigger_level .. config_error
// cfg       input      cfg_wr_en              cfg_addr, cfg_wdata
//
// One item per cycle: each item's state update and result are formed combinationally
// into the result register. in_ready is high whenever the result register is empty
// or being taken, so a stalled output holds off input by one stage only.
// Reset clears the phase, counters and result valid, and loads register defaults.
module ultrasonic_echo_ranger_unit (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     start_req,
    input  logic                     echo_level,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     trigger_level,
    output logic                     measure_done,
    output logic [20:0]              distance_mcm,
    output logic                     in_range,
    output logic                     timed_out,
    output logic                     window_done,
    output logic                     config_error,
    input  logic                     cfg_wr_en,
    input  logic [uer_pkg::AddrW-1:0] cfg_addr,
    input  logic [uer_pkg::DataW-1:0] cfg_wdata
);
    import uer_pkg::*;

    logic [9:0]        min_cm_reg, max_cm_reg;
    logic [BoundW-1:0] min_mcm_reg, max_mcm_reg;
    logic [31:0]       window_reg;
    logic [CntW-1:0]   timeout_reg;
    logic [7:0]        trig_high_reg, trig_low_reg;

    phase_t            phase_reg, phase_next, phase_eff;
    logic [CntW-1:0]   count_reg, count_next, count_inc, count_base;
    logic [31:0]       win_reg, win_next, win_eff;
    logic              out_valid_reg;
    result_t           res_reg, res_next;
    logic              accept;
    logic [CntW-1:0]   low_lim, high_lim, tmo_lim;
    logic [DistW-1:0]  dist_calc;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign low_lim  = (trig_low_reg == 8'd0) ? CntW'(1) : CntW'(trig_low_reg);
    assign high_lim = (trig_high_reg == 8'd0) ? CntW'(1) : CntW'(trig_high_reg);
    assign tmo_lim  = (timeout_reg == '0) ? CntW'(1) : timeout_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_cm_reg    <= 10'd0;
            max_cm_reg    <= 10'd500;
            min_mcm_reg   <= '0;
            max_mcm_reg   <= 20'd500000;
            window_reg    <= 32'd100000000;
            timeout_reg   <= 16'd38000;
            trig_high_reg <= 8'd10;
            trig_low_reg  <= 8'd5;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_MIN_DIST:
                begin
                    min_cm_reg  <= cfg_wdata[9:0];
                    min_mcm_reg <= BoundW'(cfg_wdata[9:0]) * MCM_PER_CM;
                end
                REG_MAX_DIST:
                begin
                    max_cm_reg  <= cfg_wdata[9:0];
                    max_mcm_reg <= BoundW'(cfg_wdata[9:0]) * MCM_PER_CM;
                end
                REG_WINDOW:       window_reg    <= cfg_wdata;
                REG_ECHO_TIMEOUT: timeout_reg   <= cfg_wdata[CntW-1:0];
                REG_TRIG_HIGH:    trig_high_reg <= cfg_wdata[7:0];
                REG_TRIG_LOW:     trig_low_reg  <= cfg_wdata[7:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        res_next   = '0;
        phase_eff  = phase_reg;
        count_base = count_reg;
        win_eff    = win_reg;

        if (phase_reg == PH_IDLE && start_req)
        begin
            if (min_cm_reg > max_cm_reg)
                res_next.config_error = 1'b1;
            else
            begin
                phase_eff  = PH_TRIG_LOW;
                count_base = '0;
                win_eff    = '0;
            end
        end

        if (phase_eff != PH_IDLE && win_eff != '1)
            win_next = win_eff + 32'd1;
        else
            win_next = win_eff;

        if (phase_eff == PH_WAIT_ECHO)
            count_base = '0;
        count_inc  = count_base + CntW'(1);
        dist_calc  = {count_base, 4'b0000} + DistW'(count_base);
        phase_next = phase_eff;
        count_next = count_base;

        unique case (phase_eff)
            PH_IDLE: ;
            PH_TRIG_LOW:
            begin
                count_next = count_inc;
                if (count_inc >= low_lim)
                begin
                    phase_next = PH_TRIG_HIGH;
                    count_next = '0;
                end
            end
            PH_TRIG_HIGH:
            begin
                res_next.trigger_level = 1'b1;
                count_next = count_inc;
                if (count_inc >= high_lim)
                begin
                    phase_next = PH_WAIT_ECHO;
                    count_next = '0;
                end
            end
            PH_WAIT_ECHO, PH_MEASURE:
            begin
                if (echo_level)
                begin
                    phase_next = PH_MEASURE;
                    count_next = count_inc;
                    if (count_inc >= tmo_lim)
                    begin
                        res_next.measure_done = 1'b1;
                        res_next.timed_out    = 1'b1;
                    end
                end
                else if (phase_eff == PH_MEASURE)
                begin
                    res_next.measure_done = 1'b1;
                    res_next.distance_mcm = dist_calc;
                end
                if (res_next.measure_done)
                begin
                    res_next.in_range = (DistW'(min_mcm_reg) < res_next.distance_mcm)
                                     && (res_next.distance_mcm < DistW'(max_mcm_reg));
                    count_next = '0;
                    if (win_next > window_reg)
                    begin
                        res_next.window_done = 1'b1;
                        phase_next = PH_IDLE;
                    end
                    else
                        phase_next = PH_TRIG_LOW;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                count_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            count_reg     <= '0;
            win_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg     <= phase_next;
                count_reg     <= count_next;
                win_reg       <= win_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= res_next;
    end

    assign out_valid     = out_valid_reg;
    assign trigger_level = res_reg.trigger_level;
    assign measure_done  = res_reg.measure_done;
    assign distance_mcm  = res_reg.distance_mcm;
    assign in_range      = res_reg.in_range;
    assign timed_out     = res_reg.timed_out;
    assign window_done   = res_reg.window_done;
    assign config_error  = res_reg.config_error;

    a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !measure_done |-> distance_mcm == '0 && !in_range && !timed_out
                                       && !window_done)
        else $error("result fields set without a finished measurement");

    a_timeout_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && timed_out |-> distance_mcm == '0 && !in_range)
        else $error("timed out measurement carries a distance");

    a_cfg_err_alone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && config_error |-> !measure_done && !trigger_level)
        else $error("refused start overlaps measurement activity");

    a_win_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept && res_next.window_done |=> phase_reg == PH_IDLE)
        else $error("window ended but sequencer still running");

endmodule

@@ bench/ultrasonic_echo_ranger_unit_tb.sv @@
// Self-checking bench for ultrasonic_echo_ranger_unit: random tick stream over valid/ready,
// result items checked against an in-bench ranging predictor.
// Depends on uer_pkg and ultrasonic_echo_ranger_unit.
module ultrasonic_echo_ranger_unit_tb;
    import uer_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned RANDOM_TICKS   = 650;
    localparam int unsigned MCM_PER_COUNT  = 17;

    typedef struct packed {
        logic start_req;
        logic echo_level;
    } tick_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic              start_req = 1'b0;
    logic              echo_level = 1'b0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              trigger_level;
    logic              measure_done;
    logic [20:0]       distance_mcm;
    logic              in_range;
    logic              timed_out;
    logic              window_done;
    logic              config_error;
    logic              cfg_wr_en = 1'b0;
    logic [AddrW-1:0]  cfg_addr = '0;
    logic [DataW-1:0]  cfg_wdata = '0;

    // predictor state and register shadow
    phase_t      cur_phase = PH_IDLE;
    logic [15:0] step_count = '0;
    logic [31:0] window_ticks = '0;
    logic [9:0]  lo_cm = 10'd0;
    logic [9:0]  hi_cm = 10'd500;
    logic [31:0] window_len = 32'd100000000;
    logic [15:0] echo_limit = 16'd38000;
    logic [7:0]  pulse_high = 8'd10;
    logic [7:0]  pulse_low = 8'd5;

    tick_t       queued_ticks[$];
    result_t     awaited_reports[$];
    tick_t       next_tick;
    result_t     oldest_report;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int unsigned idle_run = 0;
    int unsigned mismatches = 0;
    int unsigned ticks_made = 0;
    bit          idle_on = 1'b1;

    ultrasonic_echo_ranger_unit u_top (.*);

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int unsigned floor1(int unsigned v);
        return (v == 0) ? 1 : v;
    endfunction

    function automatic result_t advance_ranger(logic start, logic echo);
        result_t     rep;
        logic        finished;
        int unsigned span_mcm;
        rep = '0;
        finished = 1'b0;
        span_mcm = 0;
        if (cur_phase == PH_IDLE && start) begin
            if (lo_cm > hi_cm) begin
                rep.config_error = 1'b1;
            end else begin
                cur_phase = PH_TRIG_LOW;
                step_count = '0;
                window_ticks = '0;
            end
        end
        if (cur_phase != PH_IDLE && window_ticks != 32'hFFFF_FFFF)
            window_ticks = window_ticks + 32'd1;
        case (cur_phase)
            PH_TRIG_LOW:
            begin
                step_count = step_count + 16'd1;
                if (step_count >= floor1(pulse_low)) begin
                    cur_phase = PH_TRIG_HIGH;
                    step_count = '0;
                end
            end
            PH_TRIG_HIGH:
            begin
                rep.trigger_level = 1'b1;
                step_count = step_count + 16'd1;
                if (step_count >= floor1(pulse_high)) begin
                    cur_phase = PH_WAIT_ECHO;
                    step_count = '0;
                end
            end
            PH_WAIT_ECHO, PH_MEASURE:
            begin
                // rise tick counts as the first high tick
                if (cur_phase == PH_WAIT_ECHO && echo) begin
                    cur_phase = PH_MEASURE;
                    step_count = '0;
                end
                if (cur_phase == PH_MEASURE) begin
                    if (!echo) begin
                        finished = 1'b1;
                        span_mcm = step_count;
                        span_mcm = span_mcm * MCM_PER_COUNT;
                    end else begin
                        step_count = step_count + 16'd1;
                        if (step_count >= floor1(echo_limit)) begin
                            finished = 1'b1;
                            rep.timed_out = 1'b1;
                        end
                    end
                    if (finished) begin
                        rep.measure_done = 1'b1;
                        rep.distance_mcm = span_mcm[20:0];
                        rep.in_range = (lo_cm * 1000 < span_mcm) && (span_mcm < hi_cm * 1000);
                        step_count = '0;
                        if (window_ticks > window_len) begin
                            rep.window_done = 1'b1;
                            cur_phase = PH_IDLE;
                        end else begin
                            cur_phase = PH_TRIG_LOW;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        return rep;
    endfunction

    function automatic int unsigned draw_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (!idle_on || r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    function automatic void check_field(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endfunction

    // driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready)
                awaited_reports.push_back(advance_ranger(start_req, echo_level));
            if (!in_valid || in_ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (queued_ticks.size() != 0) begin
                    next_tick = queued_ticks.pop_front();
                    in_valid <= 1'b1;
                    start_req <= next_tick.start_req;
                    echo_level <= next_tick.echo_level;
                    gap_left = draw_gap();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (awaited_reports.size() == 0) begin
                    $error("result item with no prediction pending");
                    mismatches++;
                end else begin
                    oldest_report = awaited_reports.pop_front();
                    check_field("trigger_level", oldest_report.trigger_level, trigger_level);
                    check_field("measure_done", oldest_report.measure_done, measure_done);
                    check_field("distance_mcm", oldest_report.distance_mcm, distance_mcm);
                    check_field("in_range", oldest_report.in_range, in_range);
                    check_field("timed_out", oldest_report.timed_out, timed_out);
                    check_field("window_done", oldest_report.window_done, window_done);
                    check_field("config_error", oldest_report.config_error, config_error);
                end
            end
            if (stall_left != 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                stall_left = draw_gap();
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_run = 0;
            else
                idle_run++;
            if (idle_run >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic write_reg(reg_index_t idx, logic [31:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        case (idx)
            REG_MIN_DIST:     lo_cm = value[9:0];
            REG_MAX_DIST:     hi_cm = value[9:0];
            REG_WINDOW:       window_len = value;
            REG_ECHO_TIMEOUT: echo_limit = value[15:0];
            REG_TRIG_HIGH:    pulse_high = value[7:0];
            REG_TRIG_LOW:     pulse_low = value[7:0];
            default:
            begin
            end
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic drain();
        @(negedge clk);
        while (queued_ticks.size() != 0 || awaited_reports.size() != 0 || in_valid)
            @(negedge clk);
    endtask

    task automatic push_tick(logic start, logic echo);
        queued_ticks.push_back({start, echo});
        ticks_made++;
    endtask

    function automatic logic stray_start();
        return $urandom_range(7) == 0;
    endfunction

    // one window: start tick, then measurements aligned to the current register values
    task automatic gen_window(int unsigned measures, int unsigned fixed_high);
        int unsigned tl;
        int unsigned th;
        int unsigned tmo;
        int unsigned h;
        int unsigned m;
        int unsigned i;
        tl = floor1(pulse_low);
        th = floor1(pulse_high);
        tmo = floor1(echo_limit);
        push_tick(1'b1, 1'($urandom));
        for (m = 0; m < measures; m++) begin
            for (i = (m == 0) ? 1 : 0; i < tl + th; i++)
                push_tick(stray_start(), 1'($urandom));
            repeat ($urandom_range(3))
                push_tick(stray_start(), 1'b0);
            if (fixed_high != 0)
                h = fixed_high;
            else if (tmo == 1 || (tmo <= 300 && $urandom_range(4) == 0))
                h = tmo;
            else
                h = $urandom_range(1, (tmo > 61) ? 60 : tmo - 1);
            repeat (h)
                push_tick(stray_start(), 1'b1);
            if (h < tmo)
                push_tick(stray_start(), 1'b0);
        end
    endtask

    task automatic shuffle_config();
        int unsigned r;
        r = $urandom_range(9);
        if ($urandom_range(1))
            write_reg(REG_MIN_DIST, (r == 0) ? $urandom_range(1023) : $urandom_range(2));
        r = $urandom_range(9);
        if ($urandom_range(1))
            write_reg(REG_MAX_DIST, (r == 0) ? 1023 : (r == 1) ? $urandom_range(1023)
                                                               : $urandom_range(4));
        r = $urandom_range(9);
        if ($urandom_range(1))
            write_reg(REG_WINDOW, (r == 0) ? 32'hFFFF_FFFF : (r == 1) ? 0
                                                                       : $urandom_range(1, 200));
        r = $urandom_range(19);
        if ($urandom_range(1))
            write_reg(REG_ECHO_TIMEOUT, (r == 0) ? 38000 : (r == 1) ? 0 : $urandom_range(1, 30));
        r = $urandom_range(19);
        if ($urandom_range(1))
            write_reg(REG_TRIG_HIGH, (r == 0) ? 255 : $urandom_range(6));
        r = $urandom_range(19);
        if ($urandom_range(1))
            write_reg(REG_TRIG_LOW, (r == 0) ? 255 : $urandom_range(6));
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // refused start, zero durations
        write_reg(REG_MIN_DIST, 5);
        write_reg(REG_MAX_DIST, 3);
        write_reg(REG_WINDOW, 3);
        write_reg(REG_ECHO_TIMEOUT, 0);
        write_reg(REG_TRIG_HIGH, 0);
        write_reg(REG_TRIG_LOW, 0);
        push_tick(1'b1, 1'b1);
        push_tick(1'b0, 1'b1);
        drain();

        // short echo in range, then a timeout
        write_reg(REG_MIN_DIST, 0);
        write_reg(REG_MAX_DIST, 1);
        write_reg(REG_ECHO_TIMEOUT, 3);
        push_tick(1'b1, 1'b1);
        push_tick(1'b1, 1'b1);
        push_tick(1'b0, 1'b0);
        push_tick(1'b0, 1'b1);
        push_tick(1'b0, 1'b0);
        push_tick(1'b1, 1'b0);
        push_tick(1'b0, 1'b0);
        push_tick(1'b0, 1'b1);
        push_tick(1'b0, 1'b1);
        push_tick(1'b0, 1'b1);
        drain();

        // equal bounds, endless window, then window cut to zero mid-run
        write_reg(REG_MIN_DIST, 1023);
        write_reg(REG_MAX_DIST, 1023);
        write_reg(REG_WINDOW, 32'hFFFF_FFFF);
        push_tick(1'b1, 1'b0);
        push_tick(1'b0, 1'b1);
        push_tick(1'b0, 1'b0);
        push_tick(1'b1, 1'b1);
        push_tick(1'b0, 1'b0);
        drain();
        write_reg(REG_WINDOW, 0);
        push_tick(1'b0, 1'b0);
        push_tick(1'b0, 1'b0);
        push_tick(1'b0, 1'b1);
        push_tick(1'b0, 1'b0);
        drain();

        // longest pulses, widest timeout and a long echo that ends on a low tick
        idle_on = 1'b0;
        write_reg(REG_MIN_DIST, 0);
        write_reg(REG_ECHO_TIMEOUT, 65535);
        write_reg(REG_TRIG_HIGH, 255);
        write_reg(REG_TRIG_LOW, 255);
        gen_window(1, 120);
        drain();
        write_reg(REG_ECHO_TIMEOUT, 10);
        write_reg(REG_TRIG_HIGH, 2);
        write_reg(REG_TRIG_LOW, 1);

        ticks_made = 0;
        while (ticks_made < RANDOM_TICKS) begin
            idle_on = $urandom_range(9) < 7;
            shuffle_config();
            repeat ($urandom_range(1, 3)) begin
                if ($urandom_range(9) == 0) begin
                    repeat ($urandom_range(5, 20))
                        push_tick(1'($urandom), 1'($urandom));
                end
                gen_window($urandom_range(1, 4), 0);
                repeat ($urandom_range(3))
                    push_tick(1'b0, 1'($urandom));
            end
            drain();
        end

        drain();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
